### sv/esms_pkg.sv
// ----------------------------------------------------------------------------
// Extent set package
// Shared codes, state encoding and default sizes of the extent set unit.
// ----------------------------------------------------------------------------
package esms_pkg;

   localparam int MAX_RANGES_DEF = 16;
   localparam int PAGE_BITS_DEF  = 32;

   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_LIST   = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_OVERLAP     = 3'd1,
      ST_NOT_CONTAIN = 3'd2,
      ST_FULL        = 3'd3,
      ST_EMPTY       = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_MV_RD,
      S_MV_WR,
      S_FILL,
      S_RESULT,
      S_LIST_RD,
      S_LIST_WR
   } state_type;

endpackage

### sv/esms_if.sv
// ----------------------------------------------------------------------------
// Extent set channels
// Request and response channels with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface esms_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [31:0] range_begin;
   logic [31:0] range_end;

   modport source(output valid, mode, range_begin, range_end, input ready);
   modport sink(input valid, mode, range_begin, range_end, output ready);
endinterface

interface esms_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] out_begin;
   logic [31:0] out_end;
   logic [31:0] page_count;
   logic [4:0]  extent_count;
   logic        last;

   modport source(output valid, status, out_begin, out_end, page_count, extent_count,
                  last, input ready);
   modport sink(input valid, status, out_begin, out_end, page_count, extent_count,
                last, output ready);
endinterface

### sv/esms_mem.sv
// ----------------------------------------------------------------------------
// Extent table memory
// One write port and one read port with a registered read word.
// ----------------------------------------------------------------------------
module esms_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

`ifndef NO_ASSERTIONS
   a_no_same_addr: assert property (@(posedge clock)
      !(wr_en && rd_en && wr_addr == rd_addr))
      else $error("read and write hit the same entry in one cycle");
`endif

endmodule

### sv/extent_set_merge_split_unit.sv
// ----------------------------------------------------------------------------
// Extent set merge and split unit
// Keeps a sorted table of disjoint half-open page ranges in a memory.
// ----------------------------------------------------------------------------
// The request channel carries a mode, a begin page and an end page. Add inserts
// a range and joins it with touching neighbors, remove cuts a range out of the
// stored range that holds it, and list returns every stored range in order.
// The response channel gives one word per add, remove or no-op request, one
// per stored range for a list (one if none), with last set on the final word.
// A request is taken only when the unit is idle. An add or remove scans the
// table at one entry per cycle, then moves the entries behind the change,
// reading each entry and then writing it one place up or down, then writes
// up to two entries and loads the response word; the unit then returns to
// idle. A list reads each stored range and then loads it into the response
// word.
// Reset empties the table and clears the counts at once; no clearing pass.
// A stalled response holds in the output register and the unit waits there.
// ----------------------------------------------------------------------------
module extent_set_merge_split_unit
   import esms_pkg::*;
#(
   parameter int MAX_RANGES = MAX_RANGES_DEF,
   parameter int PAGE_BITS  = PAGE_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   esms_req_if.sink   req_chan,
   esms_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(MAX_RANGES);
   localparam int IW = $clog2(MAX_RANGES + 1);
   localparam int PW = PAGE_BITS;

   state_type state_ff, state_in;

   logic [1:0]    mode_ff;
   logic [PW-1:0] b_ff, e_ff;
   logic [IW-1:0] n_ff, idx_ff, chk_idx_ff, pos_ff, li_ff;
   logic [31:0]   pages_ff;
   logic          chk_vld_ff, fnd_ff;
   logic [PW-1:0] lb_ff, le_ff, rb_ff, re_ff;
   status_type    st_ff;
   logic [IW-1:0] mv_src_ff, mv_cnt_ff;
   logic          mv_up_ff;
   logic [1:0]    fin_cnt_ff;
   logic [AW-1:0] fin_a0_ff, fin_a1_ff;
   logic [2*PW-1:0] fin_d0_ff, fin_d1_ff;

   logic          rsp_vld_ff, rsp_last_ff;
   status_type    rsp_st_ff;
   logic [31:0]   rsp_b_ff, rsp_e_ff, rsp_pages_ff;
   logic [4:0]    rsp_n_ff;

   logic            wr_en, rd_en;
   logic [AW-1:0]   wr_addr, rd_addr;
   logic [2*PW-1:0] wr_data, rd_data;
   logic [PW-1:0]   m_b, m_e, in_b, in_e;

   logic accept, issue, ovl, hold, out_free, out_load;
   logic lm, rm, rl, rr;
   status_type dec_st;
   logic [31:0] span;

   esms_mem #(.DEPTH(MAX_RANGES), .WIDTH(2 * PW)) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign m_b = rd_data[2*PW-1:PW];
   assign m_e = rd_data[PW-1:0];
   assign in_b = PW'(req_chan.range_begin);
   assign in_e = PW'(req_chan.range_end);
   assign accept = req_chan.valid && req_chan.ready;
   assign issue = (state_ff == S_SCAN) && (idx_ff < n_ff);
   assign ovl = chk_vld_ff && (mode_ff == MODE_ADD) && (m_b < e_ff) && (b_ff < m_e);
   assign hold = chk_vld_ff && (mode_ff == MODE_REMOVE) && (m_b <= b_ff) && (e_ff <= m_e);
   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign out_load = out_free && (state_ff == S_RESULT || state_ff == S_LIST_WR);
   assign span = 32'(e_ff - b_ff);

   always_comb begin
      lm = (pos_ff != '0) && (le_ff == b_ff);
      rm = fnd_ff && (rb_ff == e_ff);
      rl = rb_ff != b_ff;
      rr = re_ff != e_ff;
      dec_st = ST_OK;
      if (mode_ff == MODE_ADD) begin
         if (!lm && !rm && n_ff >= IW'(MAX_RANGES)) begin
            dec_st = ST_FULL;
         end
      end else if (!fnd_ff) begin
         dec_st = ST_NOT_CONTAIN;
      end else if (rl && rr && n_ff >= IW'(MAX_RANGES)) begin
         dec_st = ST_FULL;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_chan.mode == MODE_LIST) begin
                  state_in = (n_ff == '0) ? S_RESULT : S_LIST_RD;
               end else if (req_chan.mode == MODE_NOP || in_e <= in_b) begin
                  state_in = S_RESULT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (ovl) begin
               state_in = S_RESULT;
            end else if (!issue && !chk_vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE:  state_in = (dec_st == ST_OK) ? S_MV_RD : S_RESULT;
         S_MV_RD: begin
            if (mv_cnt_ff != '0) begin
               state_in = S_MV_WR;
            end else begin
               state_in = (fin_cnt_ff == 2'd0) ? S_RESULT : S_FILL;
            end
         end
         S_MV_WR:   state_in = S_MV_RD;
         S_FILL:    state_in = (fin_cnt_ff <= 2'd1) ? S_RESULT : S_FILL;
         S_RESULT:  state_in = out_free ? S_IDLE : S_RESULT;
         S_LIST_RD: state_in = S_LIST_WR;
         S_LIST_WR: begin
            if (out_free) begin
               state_in = (li_ff + 1'b1 == n_ff) ? S_IDLE : S_LIST_RD;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == S_IDLE);
      rd_en = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = '0;
      wr_data = rd_data;
      case (state_ff)
         S_SCAN: begin
            rd_en = issue;
            rd_addr = idx_ff[AW-1:0];
         end
         S_MV_RD: begin
            rd_en = (mv_cnt_ff != '0);
            rd_addr = mv_src_ff[AW-1:0];
         end
         S_MV_WR: begin
            wr_en = 1'b1;
            wr_addr = mv_up_ff ? AW'(mv_src_ff + 1'b1) : AW'(mv_src_ff - 1'b1);
         end
         S_FILL: begin
            wr_en = 1'b1;
            wr_addr = fin_a0_ff;
            wr_data = fin_d0_ff;
         end
         S_LIST_RD: begin
            rd_en = 1'b1;
            rd_addr = li_ff[AW-1:0];
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff <= '0;
         pages_ff <= '0;
         rsp_vld_ff <= 1'b0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               chk_vld_ff <= 1'b0;
               if (accept) begin
                  mode_ff <= req_chan.mode;
                  b_ff <= in_b;
                  e_ff <= in_e;
                  idx_ff <= '0;
                  pos_ff <= '0;
                  li_ff <= '0;
                  fnd_ff <= 1'b0;
                  fin_cnt_ff <= 2'd0;
                  st_ff <= ((req_chan.mode == MODE_ADD || req_chan.mode == MODE_REMOVE)
                            && in_e <= in_b) ? ST_EMPTY : ST_OK;
               end
            end
            S_SCAN: begin
               idx_ff <= idx_ff + IW'(issue);
               chk_vld_ff <= issue;
               chk_idx_ff <= idx_ff;
               if (ovl) begin
                  st_ff <= ST_OVERLAP;
               end else if (chk_vld_ff && mode_ff == MODE_ADD) begin
                  if (m_b < b_ff) begin
                     pos_ff <= chk_idx_ff + 1'b1;
                     lb_ff <= m_b;
                     le_ff <= m_e;
                  end else if (!fnd_ff) begin
                     fnd_ff <= 1'b1;
                     rb_ff <= m_b;
                     re_ff <= m_e;
                  end
               end else if (hold && !fnd_ff) begin
                  fnd_ff <= 1'b1;
                  pos_ff <= chk_idx_ff;
                  rb_ff <= m_b;
                  re_ff <= m_e;
               end
            end
            S_DECIDE: begin
               st_ff <= dec_st;
               mv_cnt_ff <= '0;
               fin_cnt_ff <= 2'd1;
               if (dec_st == ST_OK) begin
                  if (mode_ff == MODE_ADD) begin
                     pages_ff <= pages_ff + span;
                     if (lm && rm) begin
                        fin_a0_ff <= AW'(pos_ff - 1'b1);
                        fin_d0_ff <= {lb_ff, re_ff};
                        mv_up_ff <= 1'b0;
                        mv_src_ff <= pos_ff + 1'b1;
                        mv_cnt_ff <= n_ff - pos_ff - 1'b1;
                        n_ff <= n_ff - 1'b1;
                     end else if (lm) begin
                        fin_a0_ff <= AW'(pos_ff - 1'b1);
                        fin_d0_ff <= {lb_ff, e_ff};
                     end else if (rm) begin
                        fin_a0_ff <= pos_ff[AW-1:0];
                        fin_d0_ff <= {b_ff, re_ff};
                     end else begin
                        fin_a0_ff <= pos_ff[AW-1:0];
                        fin_d0_ff <= {b_ff, e_ff};
                        mv_up_ff <= 1'b1;
                        mv_src_ff <= n_ff - 1'b1;
                        mv_cnt_ff <= n_ff - pos_ff;
                        n_ff <= n_ff + 1'b1;
                     end
                  end else begin
                     pages_ff <= pages_ff - span;
                     fin_a0_ff <= pos_ff[AW-1:0];
                     if (rl && rr) begin
                        fin_d0_ff <= {rb_ff, b_ff};
                        fin_a1_ff <= AW'(pos_ff + 1'b1);
                        fin_d1_ff <= {e_ff, re_ff};
                        fin_cnt_ff <= 2'd2;
                        mv_up_ff <= 1'b1;
                        mv_src_ff <= n_ff - 1'b1;
                        mv_cnt_ff <= n_ff - pos_ff - 1'b1;
                        n_ff <= n_ff + 1'b1;
                     end else if (rl) begin
                        fin_d0_ff <= {rb_ff, b_ff};
                     end else if (rr) begin
                        fin_d0_ff <= {e_ff, re_ff};
                     end else begin
                        fin_cnt_ff <= 2'd0;
                        mv_up_ff <= 1'b0;
                        mv_src_ff <= pos_ff + 1'b1;
                        mv_cnt_ff <= n_ff - pos_ff - 1'b1;
                        n_ff <= n_ff - 1'b1;
                     end
                  end
               end
            end
            S_MV_WR: begin
               mv_src_ff <= mv_up_ff ? mv_src_ff - 1'b1 : mv_src_ff + 1'b1;
               mv_cnt_ff <= mv_cnt_ff - 1'b1;
            end
            S_FILL: begin
               fin_a0_ff <= fin_a1_ff;
               fin_d0_ff <= fin_d1_ff;
               fin_cnt_ff <= fin_cnt_ff - 1'b1;
            end
            S_LIST_WR: begin
               if (out_free) begin
                  li_ff <= li_ff + 1'b1;
               end
            end
            default: begin
               chk_vld_ff <= 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_pages_ff <= pages_ff;
         rsp_n_ff <= 5'(n_ff);
         if (state_ff == S_LIST_WR) begin
            rsp_st_ff <= ST_OK;
            rsp_b_ff <= 32'(m_b);
            rsp_e_ff <= 32'(m_e);
            rsp_last_ff <= (li_ff + 1'b1 == n_ff);
         end else begin
            rsp_st_ff <= st_ff;
            rsp_b_ff <= '0;
            rsp_e_ff <= '0;
            rsp_last_ff <= 1'b1;
         end
      end
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.status = rsp_st_ff;
   assign rsp_chan.out_begin = rsp_b_ff;
   assign rsp_chan.out_end = rsp_e_ff;
   assign rsp_chan.page_count = rsp_pages_ff;
   assign rsp_chan.extent_count = rsp_n_ff;
   assign rsp_chan.last = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= IW'(MAX_RANGES))
      else $error("extent count exceeds the table size");
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("request accepted without leaving idle");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_vld_ff || rsp_chan.ready))
      else $error("response word overwritten while stalled");
   a_fill_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> fin_cnt_ff != 2'd0)
      else $error("fill state entered with no entry to write");
`endif

endmodule
